// ===== design/wam_pkg.sv =====
// Shared types, constants and small functions of the weekday alarm matcher.
// Used by every module of the block; depends on nothing else.
package wam_pkg;

   localparam int SLOTS_DEFAULT       = 16;
   localparam int BEEP_ROUNDS_DEFAULT = 11;
   localparam int SLOT_ARG_W          = 7;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_MONTH = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH_DAY   = 4'd1;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [3:0] MODE_EACH_DAY       = 4'd7;
   localparam logic [3:0] MODE_ONE_TIME       = 4'd8;
   localparam logic [3:0] MODE_WORKDAY        = 4'd9;
   localparam logic [3:0] MODE_WEEKEND        = 4'd10;
   localparam logic [3:0] MODE_WORKDAY_NO_HOL = 4'd11;

   localparam logic [2:0] WD_MONDAY   = 3'd0;
   localparam logic [2:0] WD_THURSDAY = 3'd3;
   localparam logic [2:0] WD_SATURDAY = 3'd5;

   localparam logic [1:0] MAX_PITCH     = 2'd2;
   localparam logic [3:0] DEFAULT_BEEPS = 4'd5;
   localparam logic [1:0] DEFAULT_PITCH = 2'd1;
   localparam logic [6:0] NO_MINUTE     = 7'd127;

   localparam logic [6:0] YEAR_BASE     = 7'd20;
   localparam logic [9:0] WD_OFFSET     = 10'd523;
   localparam logic [9:0] DAYS_PER_WEEK = 10'd7;
   localparam int         WD_RECIP      = 73;
   localparam int         WD_RECIP_SH   = 9;

   typedef struct packed {
      logic       cmd;
      logic [5:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [3:0] slot;
      logic       enabled;
      logic [3:0] day_mode;
      logic [3:0] beeps;
      logic [1:0] pitch;
   } req_type;

   typedef struct packed {
      logic       fired;
      logic [3:0] fired_slot;
      logic [3:0] fired_beeps;
      logic [1:0] fired_pitch;
      logic [2:0] weekday;
      logic       holiday;
   } rsp_type;

   typedef struct packed {
      logic       enabled;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [3:0] day_mode;
      logic [3:0] beeps;
      logic [1:0] pitch;
   } slot_type;

   typedef struct packed {
      logic       cmd;
      logic [3:0] slot;
      logic       in_range;
      slot_type   entry;
      logic [2:0] weekday;
      logic       holiday;
   } work_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

   localparam slot_type SLOT_DEFAULT = '{
      enabled: 1'b0, hour: 5'd0, minute: 6'd0, day_mode: MODE_EACH_DAY,
      beeps: DEFAULT_BEEPS, pitch: DEFAULT_PITCH};

   // Contents of a slot after reset: two presets, the rest default.
   function automatic slot_type slot_reset(input logic [SLOT_ARG_W-1:0] idx);
      slot_type s;
      s = SLOT_DEFAULT;
      if (idx == 7'd0) begin
         s.enabled  = 1'b1;
         s.hour     = 5'd7;
         s.minute   = 6'd45;
         s.day_mode = MODE_WORKDAY_NO_HOL;
      end else if (idx == 7'd1) begin
         s.enabled  = 1'b1;
         s.hour     = 5'd6;
         s.minute   = 6'd20;
         s.day_mode = 4'd2;
      end
      return s;
   endfunction

   // The month term (13 * (m + 1)) / 5 of the weekday formula.
   function automatic logic [5:0] month_term(input logic [3:0] m);
      logic [5:0] t;
      case (m)
         4'd0:    t = 6'd2;
         4'd1:    t = 6'd5;
         4'd2:    t = 6'd7;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         4'd13:   t = 6'd36;
         4'd14:   t = 6'd39;
         default: t = 6'd41;
      endcase
      return t;
   endfunction

endpackage

// ===== design/weekday_alarm_matcher.sv =====
// Weekday alarm matcher: a write item passes through the front register, the queue and the
// back part's emit state; a tick for a new minute also runs the slot scan that reads one table entry per cycle.
// The front accepts new items while the back part still works on earlier ones, until the queue is full.
// Reset is synchronous and active high; the table reads as its preset contents at once
// through per-slot valid bits, so no clearing pass is needed.
module weekday_alarm_matcher #(
   parameter int SLOTS       = wam_pkg::SLOTS_DEFAULT,
   parameter int BEEP_ROUNDS = wam_pkg::BEEP_ROUNDS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  wam_pkg::req_type                    req_item,
   output logic                                empty,
   input  logic                                pop,
   output wam_pkg::rsp_type                    rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wam_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wam_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import wam_pkg::*;

   logic       birth_month_ff;
   logic [3:0] birth_month_q_ff;
   logic [4:0] birth_day_ff;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;
   work_type   q_wdata;
   work_type   q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_month_ff   <= 1'b0;
         birth_month_q_ff <= 4'd0;
         birth_day_ff     <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BIRTH_MONTH: begin
               birth_month_q_ff <= csr_wdata[3:0];
               birth_month_ff   <= (csr_wdata[3:0] != 4'd0);
            end
            CSR_BIRTH_DAY: begin
               birth_day_ff <= csr_wdata;
            end
            default: begin
               birth_day_ff <= birth_day_ff;
            end
         endcase
      end
   end

   wam_front #(
      .SLOTS       (SLOTS),
      .BEEP_ROUNDS (BEEP_ROUNDS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_full    (full),
      .req_item    (req_item),
      .birth_month (birth_month_ff ? birth_month_q_ff : 4'd0),
      .birth_day   (birth_day_ff),
      .q_push      (q_push),
      .q_full      (q_full),
      .q_data      (q_wdata)
   );

   wam_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   wam_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== design/wam_queue.sv =====
// Two-entry queue of classified items between the front and back parts.
// Depends on wam_pkg for the item type.
module wam_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wam_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output wam_pkg::work_type pop_data,
   output logic              empty
);
   import wam_pkg::*;

   work_type   entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/wam_front.sv =====
// Front part: accepts items, saturates write settings, works out the weekday
// and holiday flag of a tick. Depends on wam_pkg.
module wam_front #(
   parameter int SLOTS       = wam_pkg::SLOTS_DEFAULT,
   parameter int BEEP_ROUNDS = wam_pkg::BEEP_ROUNDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  wam_pkg::req_type  req_item,
   input  logic [3:0]        birth_month,
   input  logic [4:0]        birth_day,
   output logic              q_push,
   input  logic              q_full,
   output wam_pkg::work_type q_data
);
   import wam_pkg::*;

   localparam logic [3:0] MAX_BEEPS = 4'(BEEP_ROUNDS - 1);

   logic       a_vld_ff;
   logic       a_vld_in;
   logic       a_cmd_ff;
   logic [3:0] a_slot_ff;
   logic       a_in_range_ff;
   slot_type   a_entry_ff;
   logic [3:0] a_month_ff;
   logic [4:0] a_day_ff;
   logic [9:0] a_sum_ff;

   logic       accept;
   slot_type   entry_in;
   logic [6:0] year_in;
   logic [3:0] mon_in;
   logic [9:0] sum_in;

   logic [16:0] prod;
   logic [7:0]  quot;
   logic [9:0]  rem_wide;
   logic [3:0]  rem;
   logic [2:0]  wd;
   logic        hol;

   assign req_full = a_vld_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = a_vld_ff && !q_full;

   always_comb begin
      entry_in.enabled  = req_item.enabled;
      entry_in.hour     = req_item.hour;
      entry_in.minute   = req_item.minute;
      entry_in.day_mode = req_item.day_mode;
      entry_in.beeps    = (req_item.beeps > MAX_BEEPS) ? MAX_BEEPS : req_item.beeps;
      entry_in.pitch    = (req_item.pitch > MAX_PITCH) ? MAX_PITCH : req_item.pitch;

      year_in = 7'(req_item.year) + YEAR_BASE;
      mon_in  = req_item.month;
      if (req_item.month <= 4'd2) begin
         mon_in  = req_item.month + 4'd12;
         year_in = year_in - 7'd1;
      end
      sum_in = 10'(req_item.day) + 10'(month_term(mon_in)) + 10'(year_in)
             + 10'(year_in >> 2) + WD_OFFSET;

      a_vld_in = accept ? 1'b1 : (q_push ? 1'b0 : a_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cmd_ff      <= req_item.cmd;
         a_slot_ff     <= req_item.slot;
         a_in_range_ff <= (7'(req_item.slot) < 7'(SLOTS));
         a_entry_ff    <= entry_in;
         a_month_ff    <= req_item.month;
         a_day_ff      <= req_item.day;
         a_sum_ff      <= sum_in;
      end
   end

   // The quotient estimate by seven is low by at most one.
   always_comb begin
      prod     = 17'(a_sum_ff) * 17'(WD_RECIP);
      quot     = prod[16:WD_RECIP_SH];
      rem_wide = a_sum_ff - 10'(10'(quot) * DAYS_PER_WEEK);
      rem      = rem_wide[3:0];
      wd       = (rem >= 4'(DAYS_PER_WEEK)) ? 3'(rem - 4'(DAYS_PER_WEEK)) : rem[2:0];

      hol = 1'b0;
      case (a_month_ff)
         4'd1: hol = (a_day_ff == 5'd1)
                  || (wd == WD_MONDAY && a_day_ff > 5'd14 && a_day_ff <= 5'd21);
         4'd2: hol = (wd == WD_MONDAY && a_day_ff > 5'd14 && a_day_ff <= 5'd21);
         4'd5: hol = (wd == WD_MONDAY && a_day_ff > 5'd24);
         4'd6: hol = (a_day_ff == 5'd19);
         4'd7: hol = (a_day_ff == 5'd4);
         4'd9: hol = (wd == WD_MONDAY && a_day_ff <= 5'd7);
         4'd11: hol = (a_day_ff == 5'd11)
                   || (wd == WD_THURSDAY && a_day_ff > 5'd21 && a_day_ff <= 5'd28);
         4'd12: hol = (a_day_ff == 5'd25);
         default: hol = 1'b0;
      endcase
      if (birth_month != 4'd0 && a_month_ff == birth_month && a_day_ff == birth_day) begin
         hol = 1'b1;
      end

      q_data.cmd      = a_cmd_ff;
      q_data.slot     = a_slot_ff;
      q_data.in_range = a_in_range_ff;
      q_data.entry    = a_entry_ff;
      q_data.weekday  = wd;
      q_data.holiday  = hol;
   end

endmodule

// ===== design/wam_back.sv =====
// Back part: holds the alarm table, applies writes, scans the slots on a tick
// and keeps the result register. Depends on wam_pkg.
module wam_back #(
   parameter int SLOTS = wam_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  wam_pkg::work_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output wam_pkg::rsp_type  rsp_item
);
   import wam_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   slot_type             mem [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   slot_type             rd_data_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_type             wr_data;

   back_state_type       state_ff;
   back_state_type       state_in;
   work_type             cur_ff;
   work_type             cur_in;
   logic [CNT_W-1:0]     scan_ff;
   logic [CNT_W-1:0]     scan_in;
   logic                 chk_vld_ff;
   logic                 chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic [IDX_W-1:0]     chk_idx_in;
   logic [6:0]           last_ff;
   logic [6:0]           last_in;
   rsp_type              res_ff;
   rsp_type              res_in;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   rsp_type              out_ff;
   logic                 out_load;
   slot_type             entry;
   logic                 hit;

   function automatic logic mode_matches(input logic [3:0] mode, input logic [2:0] wd,
                                         input logic hol);
      logic m;
      m = (mode == MODE_EACH_DAY) || (mode == MODE_ONE_TIME) || (mode == {1'b0, wd})
       || (mode == MODE_WEEKEND && wd >= WD_SATURDAY)
       || (wd < WD_SATURDAY && (mode == MODE_WORKDAY || (mode == MODE_WORKDAY_NO_HOL && !hol)));
      return m;
   endfunction

   assign rsp_empty = !out_vld_ff;
   assign rsp_item  = out_ff;
   assign rd_addr   = scan_ff[IDX_W-1:0];

   always_comb begin
      entry = rd_vld_ff ? rd_data_ff : slot_reset(SLOT_ARG_W'(chk_idx_ff));
      hit   = entry.enabled && entry.minute == cur_ff.entry.minute
           && entry.hour == cur_ff.entry.hour
           && mode_matches(entry.day_mode, cur_ff.weekday, cur_ff.holiday);
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      last_in    = last_ff;
      res_in     = res_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = IDX_W'(q_data.slot);
      wr_data    = q_data.entry;
      out_load   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               res_in = '0;
               if (q_data.cmd == CMD_WRITE) begin
                  wr_en    = q_data.in_range;
                  state_in = BK_EMIT;
               end else begin
                  res_in.weekday = q_data.weekday;
                  res_in.holiday = q_data.holiday;
                  if ({1'b0, q_data.entry.minute} == last_ff) begin
                     state_in = BK_EMIT;
                  end else begin
                     last_in  = {1'b0, q_data.entry.minute};
                     scan_in  = '0;
                     state_in = BK_SCAN;
                  end
               end
            end
         end
         BK_SCAN: begin
            chk_vld_in = (scan_ff < CNT_W'(SLOTS));
            chk_idx_in = scan_ff[IDX_W-1:0];
            if (chk_vld_in) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (hit) begin
                  res_in.fired       = 1'b1;
                  res_in.fired_slot  = 4'(chk_idx_ff);
                  res_in.fired_beeps = entry.beeps;
                  res_in.fired_pitch = entry.pitch;
                  wr_en              = (entry.day_mode == MODE_ONE_TIME);
                  wr_addr            = chk_idx_ff;
                  wr_data            = SLOT_DEFAULT;
                  chk_vld_in         = 1'b0;
                  state_in           = BK_EMIT;
               end else if (chk_idx_ff == IDX_W'(SLOTS - 1)) begin
                  last_in    = NO_MINUTE;
                  chk_vld_in = 1'b0;
                  state_in   = BK_EMIT;
               end
            end
         end
         BK_EMIT: begin
            if (!out_vld_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      out_vld_in = out_load ? 1'b1 : ((rsp_pop && out_vld_ff) ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
         last_ff    <= NO_MINUTE;
         out_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
         last_ff    <= last_in;
         out_vld_ff <= out_vld_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      chk_idx_ff <= chk_idx_in;
      res_ff     <= res_in;
      rd_vld_ff  <= valid_ff[rd_addr];
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule
